// ===== sv/merq_pkg.sv =====
// shared types and operation codes for the masked event ring queue
package merq_pkg;

	typedef enum logic [1:0] {
		OP_POST = 2'd0,
		OP_GET  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// command handed from the front to the back
	typedef struct packed {
		op_t         op;
		logic [15:0] event_type;
		logic [15:0] message;
		logic [15:0] modifiers;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] type_mask;
		logic [31:0] tick_now;
	} cmd_t;

	// one result transaction
	typedef struct packed {
		logic        found;
		logic [15:0] out_type;
		logic [15:0] out_message;
		logic [15:0] out_modifiers;
		logic [15:0] out_x;
		logic [15:0] out_y;
		logic [31:0] out_time;
	} res_t;

endpackage

// ===== sv/merq_front.sv =====
// front part: accepts input transactions, drops unused codes, queues commands
module merq_front import merq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t in_cmd,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_take
);

	// two entry command queue
	cmd_t       buf_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       acc;
	logic       keep;

	assign full      = (cnt_q == 2'd2);
	assign acc       = push && !full;
	assign keep      = acc && (in_cmd.op != OP_NONE);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (keep) begin
			buf_q[wptr_q] <= in_cmd;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (keep) begin
				wptr_q <= ~wptr_q;
			end
			if (cmd_take) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, keep} - {1'b0, cmd_take};
		end
	end

endmodule

// ===== sv/merq_back.sv =====
// back part: ring store, slot scan and result register
module merq_back import merq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	output logic empty,
	input  logic pop,
	output res_t res
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_TEST = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	logic [15:0] mem_type [QUEUE_DEPTH];
	logic [95:0] mem_data [QUEUE_DEPTH];

	state_t      state_q;
	logic [IW-1:0] head_q, tail_q, idx_q;
	logic [15:0] rd_type_q;
	logic [95:0] rd_data_q;
	logic        res_valid_q;
	res_t        res_q;
	cmd_t        cur_q;
	logic        clr_we;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	assign empty    = !res_valid_q;
	assign res      = res_q;
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid &&
		(cmd.op == OP_POST || !res_valid_q);
	assign clr_we   = (state_q == ST_TEST) && ((rd_type_q & cur_q.type_mask) != 16'd0)
		&& (cur_q.op == OP_GET);

	// slot memories, one write and one registered read; command held during the scan
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q <= cmd;
		end
		if (cmd_take && cmd.op == OP_POST) begin
			mem_type[tail_q] <= cmd.event_type;
			mem_data[tail_q] <= {cmd.message, cmd.modifiers, cmd.pos_x, cmd.pos_y,
				cmd.tick_now};
		end else if (clr_we) begin
			mem_type[idx_q] <= 16'd0;
		end
		rd_type_q <= mem_type[idx_q];
		rd_data_q <= mem_data[idx_q];
	end

	// scan sequencer and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.op == OP_POST) begin
							tail_q <= nxt(tail_q);
							if (nxt(tail_q) == head_q) begin
								head_q <= nxt(head_q);
							end
							state_q <= ST_DONE;
						end else begin
							idx_q   <= head_q;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (idx_q == tail_q) begin
						res_q       <= '{found: 1'b0, out_type: 16'd0, out_message: 16'd0,
							out_modifiers: cur_q.modifiers, out_x: cur_q.pos_x,
							out_y: cur_q.pos_y, out_time: 32'd0};
						res_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if ((rd_type_q & cur_q.type_mask) != 16'd0) begin
						res_q       <= '{found: 1'b1, out_type: rd_type_q,
							out_message: rd_data_q[95:80], out_modifiers: rd_data_q[79:64],
							out_x: rd_data_q[63:48], out_y: rd_data_q[47:32],
							out_time: rd_data_q[31:0]};
						res_valid_q <= 1'b1;
						if (cur_q.op == OP_GET) begin
							head_q <= nxt(head_q);
						end
						state_q <= ST_DONE;
					end else begin
						idx_q   <= nxt(idx_q);
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/masked_event_ring_queue.sv =====
// top level of the masked event ring queue
//
// Both sides look like queues. Push an event transaction with push while
// full is low; read results while empty is low and take them with pop.
// operation 0 posts an event at the tail (no result, the oldest event is
// lost when the ring fills), 1 gets the first event whose type meets
// type_mask, 2 peeks it, 3 is ignored. A get or peek gives one result:
// the matched event, or a null event carrying the input position and
// modifiers.
// Timing: a command reaches the back part through the front command queue.
// A post passes through ST_IDLE and ST_DONE. A query walks ST_READ and
// ST_TEST once per slot scanned from head to tail, then ends in ST_DONE;
// at most QUEUE_DEPTH-1 events are held, and the back part takes no new
// command until it is back in ST_IDLE. The scan is set by the single
// read port of the slot memory walked one slot at a time.
// A two entry command queue sits between the front and the back part.
// Reset clears the pointers and all queues; slot contents stay undefined.
// While a result waits unpopped, posts go on but the next query waits.
module masked_event_ring_queue import merq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [15:0] event_type,
	input  logic [15:0] message,
	input  logic [15:0] modifiers,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [15:0] type_mask,
	input  logic [31:0] tick_now,
	output logic        empty,
	input  logic        pop,
	output logic        found,
	output logic [15:0] out_type,
	output logic [15:0] out_message,
	output logic [15:0] out_modifiers,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [31:0] out_time
);

	cmd_t in_cmd;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;
	res_t res;

	assign in_cmd = '{op: op_t'(operation), event_type: event_type, message: message,
		modifiers: modifiers, pos_x: pos_x, pos_y: pos_y, type_mask: type_mask,
		tick_now: tick_now};

	merq_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_cmd(in_cmd),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	merq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .empty(empty), .pop(pop), .res(res)
	);

	assign found         = res.found;
	assign out_type      = res.out_type;
	assign out_message   = res.out_message;
	assign out_modifiers = res.out_modifiers;
	assign out_x         = res.out_x;
	assign out_y         = res.out_y;
	assign out_time      = res.out_time;

endmodule

// ===== verif/masked_event_ring_queue_tb.sv =====
// testbench for the masked event ring queue: predicted results checked against the block
`timescale 1ns / 100ps

module masked_event_ring_queue_tb;
	import merq_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 600000;

	logic clk, arst_n, push, full, empty, pop;
	logic [1:0] operation;
	logic [15:0] event_type, message, modifiers, type_mask;
	logic signed [15:0] pos_x, pos_y;
	logic [31:0] tick_now;
	logic found;
	logic [15:0] out_type, out_message, out_modifiers;
	logic signed [15:0] out_x, out_y;
	logic [31:0] out_time;

	masked_event_ring_queue #(.QUEUE_DEPTH(DEPTH)) uut (.*);

	// predictor state: one copy of the event ring
	res_t ring [DEPTH];
	logic [3:0] head_ptr, tail_ptr;
	res_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	bit pop_enable = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// apply one transaction to the ring and queue any result
	function automatic void predict_event(cmd_t c);
		logic [3:0] idx;
		res_t r;
		bit hit;
		idx = head_ptr;
		hit = 1'b0;
		case (c.op)
			OP_POST: begin
				ring[tail_ptr] = '{1'b1, c.event_type, c.message, c.modifiers,
					c.pos_x, c.pos_y, c.tick_now};
				tail_ptr++;
				if (tail_ptr == head_ptr)
					head_ptr++;
			end
			OP_GET, OP_PEEK: begin
				for (int n = 0; n < DEPTH && idx != tail_ptr && !hit; n++) begin
					if ((ring[idx].out_type & c.type_mask) != 0)
						hit = 1'b1;
					else
						idx++;
				end
				if (hit) begin
					r = ring[idx];
					r.found = 1'b1;
					if (c.op == OP_GET) begin
						ring[idx].out_type = '0;
						head_ptr++;
					end
				end else begin
					r = '{1'b0, 16'd0, 16'd0, c.modifiers, c.pos_x, c.pos_y, 32'd0};
				end
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// send one transaction, with a random gap first
	task automatic send_event(cmd_t c);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		operation <= c.op;
		event_type <= c.event_type;
		message <= c.message;
		modifiers <= c.modifiers;
		pos_x <= c.pos_x;
		pos_y <= c.pos_y;
		type_mask <= c.type_mask;
		tick_now <= c.tick_now;
		do @(posedge clk); while (full);
		predict_event(c);
		@(negedge clk);
	endtask

	function automatic cmd_t random_cmd(int op_weight_post);
		cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		c.op = (r < op_weight_post) ? OP_POST : (r < 80) ? OP_GET : (r < 97) ? OP_PEEK : OP_NONE;
		// sparse one-hot-ish types so masks discriminate
		c.event_type = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(1 << $urandom_range(0, 15));
		c.message = 16'($urandom);
		c.modifiers = 16'($urandom);
		c.pos_x = 16'($urandom);
		c.pos_y = 16'($urandom);
		c.type_mask = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'($urandom_range(1, 255) << $urandom_range(0, 8));
		c.tick_now = $urandom;
		return c;
	endfunction

	// result checker
	always @(posedge clk) begin
		res_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (found !== e.found) begin
					$error("found exp %0h got %0h", e.found, found); errors++;
				end
				if (out_type !== e.out_type) begin
					$error("out_type exp %0h got %0h", e.out_type, out_type); errors++;
				end
				if (out_message !== e.out_message) begin
					$error("out_message exp %0h got %0h", e.out_message, out_message); errors++;
				end
				if (out_modifiers !== e.out_modifiers) begin
					$error("out_modifiers exp %0h got %0h", e.out_modifiers, out_modifiers);
					errors++;
				end
				if (out_x !== e.out_x) begin
					$error("out_x exp %0h got %0h", e.out_x, out_x); errors++;
				end
				if (out_y !== e.out_y) begin
					$error("out_y exp %0h got %0h", e.out_y, out_y); errors++;
				end
				if (out_time !== e.out_time) begin
					$error("out_time exp %0h got %0h", e.out_time, out_time); errors++;
				end
			end
		end
	end

	// random pop stalls
	always @(negedge clk) begin
		if (!pop_enable)
			pop <= 1'b1;
		else if ($urandom_range(0, 29) == 0)
			pop <= 1'b0;
		else if (!pop && $urandom_range(0, 7) != 0)
			pop <= pop;
		else
			pop <= ($urandom_range(0, 2) != 0);
	end

	task automatic test_directed();
		cmd_t c;
		c = '{OP_GET, 16'h0, 16'h0, 16'hFFFF, -16'sd32768, 16'sd32767, 16'hFFFF, 32'h0};
		send_event(c);
		c.op = OP_PEEK; c.modifiers = 16'h0; c.pos_x = 16'sd32767; c.pos_y = -16'sd32768;
		send_event(c);
		// post extremes and a zero type
		send_event('{OP_POST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 0, 32'hFFFFFFFF});
		send_event('{OP_POST, 16'h0, 16'h1234, 16'h0, 16'h8000, 16'h7FFF, 0, 32'h0});
		send_event('{OP_POST, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 32'h1});
		send_event('{OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1});
		send_event('{OP_PEEK, 0, 0, 16'h5, 16'h6, 16'h7, 16'h0000, 0});
		send_event('{OP_PEEK, 0, 0, 0, 0, 0, 16'h0001, 0});
		// get matching the head, then a deeper match that drops the head
		send_event('{OP_GET, 0, 0, 0, 0, 0, 16'h0001, 0});
		send_event('{OP_GET, 0, 0, 0, 0, 0, 16'hFFFF, 0});
		// overflow: post past depth
		for (int i = 0; i < DEPTH + 3; i++)
			send_event('{OP_POST, 16'(1 << (i % 16)), 16'(i), 16'(i), 16'(i), 16'(i), 0, 32'(i)});
		send_event('{OP_GET, 0, 0, 0, 0, 0, 16'h8000, 0});
		send_event('{OP_PEEK, 0, 0, 0, 0, 0, 16'hFFFF, 0});
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 1900; i++)
			send_event(random_cmd((i / 200) % 2 ? 35 : 60));
	endtask

	initial begin
		int waited;
		arst_n = 1'b0; push = 1'b0; pop = 1'b0; operation = OP_NONE;
		event_type = 0; message = 0; modifiers = 0; pos_x = 0; pos_y = 0;
		type_mask = 0; tick_now = 0;
		head_ptr = 0; tail_ptr = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_traffic();
		push <= 1'b0;
		pop_enable = 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4 * DEPTH + 10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
